// ----- src/igc_pkg.sv -----
// ----------------------------------------------------------------------------
// igc_pkg: shared types and constants for the intensity gated centroid
// Request and result structs, the job passed from the accumulating front end
// to the dividing back end, register indexes and datapath widths.
// ----------------------------------------------------------------------------
package igc_pkg;

  localparam int CoordBits  = 32;
  localparam int IntenBits  = 16;
  localparam int CntW       = 21;
  localparam int SumW       = 52;
  localparam int MaxPoints  = 1048576;
  localparam int RemW       = CntW + 1;
  localparam int StepW      = $clog2(SumW + 1);
  localparam int CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] RegIntenLow  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegIntenHigh = CfgIdxW'(1);

  localparam logic [IntenBits-1:0] IntenLowRst  = IntenBits'(1100);
  localparam logic [IntenBits-1:0] IntenHighRst = IntenBits'(2000);

  typedef struct packed {
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic signed [CoordBits-1:0] point_z;
    logic [IntenBits-1:0]        intensity;
    logic                        last_point;
  } igc_req_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] centroid_x;
    logic signed [CoordBits-1:0] centroid_y;
    logic signed [CoordBits-1:0] centroid_z;
    logic [CntW-1:0]             point_count;
    logic                        empty_cloud;
    logic                        count_overflow;
  } igc_res_t;

  typedef struct packed {
    logic signed [SumW-1:0] sum_x;
    logic signed [SumW-1:0] sum_y;
    logic signed [SumW-1:0] sum_z;
    logic [CntW-1:0]        count;
    logic                   overflow;
  } igc_job_t;

endpackage

// ----- src/igc_front.sv -----
// ----------------------------------------------------------------------------
// igc_front: intensity gate and coordinate accumulator
// Holds the intensity bounds, sums the coordinates of gated requests and
// hands one job per cloud to the job queue, then clears the sums.
// ----------------------------------------------------------------------------
module igc_front import igc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [IntenBits-1:0] cfg_data_i,
  input  logic               req_valid_i,
  input  igc_req_t           req_i,
  output logic               job_push_o,
  output igc_job_t           job_o
);

  logic [IntenBits-1:0]   low_q, high_q;
  logic signed [SumW-1:0] sx_q, sy_q, sz_q, sx_d, sy_d, sz_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;
  logic                   gate, room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= IntenLowRst;
      high_q <= IntenHighRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegIntenLow) begin
        low_q <= cfg_data_i;
      end
      if (cfg_index_i == RegIntenHigh) begin
        high_q <= cfg_data_i;
      end
    end
  end

  assign gate = (req_i.intensity > low_q) && (req_i.intensity < high_q);
  assign room = cnt_q < CntW'(MaxPoints);

  always_comb begin
    sx_d  = sx_q;
    sy_d  = sy_q;
    sz_d  = sz_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (gate && room) begin
      sx_d  = sx_q + {{(SumW-CoordBits){req_i.point_x[CoordBits-1]}}, req_i.point_x};
      sy_d  = sy_q + {{(SumW-CoordBits){req_i.point_y[CoordBits-1]}}, req_i.point_y};
      sz_d  = sz_q + {{(SumW-CoordBits){req_i.point_z[CoordBits-1]}}, req_i.point_z};
      cnt_d = cnt_q + CntW'(1);
    end else if (gate) begin
      ovf_d = 1'b1;
    end
  end

  assign job_push_o     = req_valid_i && req_i.last_point;
  assign job_o.sum_x    = sx_d;
  assign job_o.sum_y    = sy_d;
  assign job_o.sum_z    = sz_d;
  assign job_o.count    = cnt_d;
  assign job_o.overflow = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q  <= '0;
      sy_q  <= '0;
      sz_q  <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (req_valid_i) begin
      if (req_i.last_point) begin
        sx_q  <= '0;
        sy_q  <= '0;
        sz_q  <= '0;
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        sx_q  <= sx_d;
        sy_q  <= sy_d;
        sz_q  <= sz_d;
        cnt_q <= cnt_d;
        ovf_q <= ovf_d;
      end
    end
  end

endmodule

// ----- src/igc_jobq.sv -----
// ----------------------------------------------------------------------------
// igc_jobq: two-entry job queue
// Decouples the accumulating front end from the dividing back end.
// ----------------------------------------------------------------------------
module igc_jobq import igc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  igc_job_t job_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output igc_job_t job_o
);

  igc_job_t   mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign job_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ----- src/igc_back.sv -----
// ----------------------------------------------------------------------------
// igc_back: centroid divider and result register
// Divides the three sums by the point count with three bit-serial restoring
// dividers working side by side, then holds the result until it is taken.
// ----------------------------------------------------------------------------
module igc_back import igc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  input  igc_job_t job_i,
  output logic     job_pop_o,
  input  logic     pop_i,
  output logic     empty_o,
  output igc_res_t res_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StHold = 2'd2;

  logic [1:0]        st_q, st_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [SumW-1:0]   dvd_q [3];
  logic [SumW-1:0]   dvd_d [3];
  logic [RemW-1:0]   rem_q [3];
  logic [RemW-1:0]   rem_d [3];
  logic [2:0]        neg_q, neg_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              ovf_q, ovf_d, emp_q, emp_d;
  logic              out_vld_q, out_vld_d;
  igc_res_t          out_q, out_d;
  logic signed [SumW-1:0] sums [3];
  logic [SumW-1:0]   quo [3];
  logic [RemW-1:0]   trial [3];

  assign sums[0] = job_i.sum_x;
  assign sums[1] = job_i.sum_y;
  assign sums[2] = job_i.sum_z;

  always_comb begin
    st_d      = st_q;
    step_d    = step_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    neg_d     = neg_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    emp_d     = emp_q;
    out_vld_d = out_vld_q && !pop_i;
    out_d     = out_q;
    job_pop_o = 1'b0;
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem_q[i][RemW-2:0], dvd_q[i][SumW-1]};
      quo[i]   = neg_q[i] ? (~dvd_q[i] + SumW'(1)) : dvd_q[i];
    end
    unique case (st_q)
      StIdle: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          cnt_d     = job_i.count;
          ovf_d     = job_i.overflow;
          emp_d     = job_i.count == '0;
          step_d    = '0;
          for (int i = 0; i < 3; i++) begin
            neg_d[i] = sums[i][SumW-1] && (job_i.count != '0);
            dvd_d[i] = (job_i.count == '0) ? '0 :
                       (sums[i][SumW-1] ? SumW'(-sums[i]) : SumW'(sums[i]));
            rem_d[i] = '0;
          end
          st_d = (job_i.count == '0) ? StHold : StRun;
        end
      end
      StRun: begin
        for (int i = 0; i < 3; i++) begin
          if (trial[i] >= {1'b0, cnt_q}) begin
            rem_d[i] = trial[i] - {1'b0, cnt_q};
            dvd_d[i] = {dvd_q[i][SumW-2:0], 1'b1};
          end else begin
            rem_d[i] = trial[i];
            dvd_d[i] = {dvd_q[i][SumW-2:0], 1'b0};
          end
        end
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(SumW - 1)) begin
          st_d = StHold;
        end
      end
      StHold: begin
        if (!out_vld_q || pop_i) begin
          out_vld_d            = 1'b1;
          out_d.centroid_x     = quo[0][CoordBits-1:0];
          out_d.centroid_y     = quo[1][CoordBits-1:0];
          out_d.centroid_z     = quo[2][CoordBits-1:0];
          out_d.point_count    = cnt_q;
          out_d.empty_cloud    = emp_q;
          out_d.count_overflow = ovf_q;
          st_d                 = StIdle;
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
    ovf_q <= ovf_d;
    emp_q <= emp_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      step_q    <= step_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign empty_o = !out_vld_q;
  assign res_o   = out_q;

endmodule

// ----- src/intensity_gated_centroid.sv -----
// ----------------------------------------------------------------------------
// intensity_gated_centroid: centroid of the intensity-gated points of a cloud
// Accumulates gated point coordinates one request per cycle while not full;
// a separate back end divides the sums by the point count once per cloud.
// ----------------------------------------------------------------------------
// Throughput: one point request per cycle while full is low; the back end
// divides one cloud at a time with its 52-step bit-serial dividers, going
// from idle through run to hold, where a free result register takes it.
// full is raised while two finished clouds wait for the divider.
// Reset restores the intensity bounds to 1100 and 2000, clears the sums and
// empties the job queue and the result register.
module intensity_gated_centroid import igc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [IntenBits-1:0] cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  igc_req_t             push_data_i,
  output logic                 empty,
  input  logic                 pop,
  output igc_res_t             pop_data_o
);

  logic     job_push, job_full, job_valid, job_pop, req_valid;
  igc_job_t job_in, job_out;

  assign cfg_ready_o = 1'b1;
  assign full        = job_full;
  assign req_valid   = push && !job_full;

  igc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (req_valid),
    .req_i       (push_data_i),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  igc_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  igc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (pop_data_o)
  );

endmodule

// ----- src/igc_checker.sv -----
// ----------------------------------------------------------------------------
// igc_checker: port-level checks for the intensity gated centroid
// Watches the result queue and the consistency of the result fields.
// ----------------------------------------------------------------------------
module igc_checker import igc_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 empty,
  input logic                 pop,
  input igc_res_t             pop_data_o
);

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(pop_data_o)))
    else $error("waiting result changed or vanished");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop_data_o.empty_cloud) |->
      (pop_data_o.point_count == '0 && pop_data_o.centroid_x == '0 &&
       pop_data_o.centroid_y == '0 && pop_data_o.centroid_z == '0))
    else $error("empty cloud result carries nonzero fields");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop_data_o.empty_cloud) |-> (pop_data_o.point_count != '0))
    else $error("nonempty result with zero count");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pop_data_o.point_count <= CntW'(MaxPoints)))
    else $error("point count above capacity");

endmodule

bind intensity_gated_centroid igc_checker u_igc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .pop_data_o  (pop_data_o)
);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for the intensity gated centroid
// Drives point requests into the block, keeps its own running sums, count and
// intensity bounds, and predicts one centroid result per finished cloud.
// Every popped result is compared field by field with the oldest prediction.
// The tests cover the bound edges, empty and crossed windows, ignored register
// writes, long receiver hold-offs and random clouds under several idling
// patterns.
// ----------------------------------------------------------------------------
module tb;
  import igc_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int DrainCycles = 200;
  localparam int HoldCycles = 400;
  localparam int PhaseItems = 375;

  localparam logic [CfgIdxW-1:0] RegSpareA = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegSpareB = CfgIdxW'(3);

  localparam logic [CoordBits-1:0] CoordMin = 32'h8000_0000;
  localparam logic [CoordBits-1:0] CoordMax = 32'h7fff_ffff;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [IntenBits-1:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  igc_req_t push_data_i = '0;
  logic empty;
  logic pop = 1'b0;
  igc_res_t pop_data_o;

  logic [IntenBits-1:0] low_bound = IntenLowRst;
  logic [IntenBits-1:0] high_bound = IntenHighRst;
  longint sum_x = 0;
  longint sum_y = 0;
  longint sum_z = 0;
  int unsigned point_total = 0;
  bit overflow_seen = 1'b0;
  igc_res_t centroid_q[$];
  igc_res_t cloud_want;

  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatch_count = 0;

  intensity_gated_centroid dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .push_data_i (push_data_i),
    .empty       (empty),
    .pop         (pop),
    .pop_data_o  (pop_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go) begin
      hold_left <= HoldCycles;
    end
  end

  always @(posedge clk_i) begin
    pop <= (hold_left == 0) && !hold_go && ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what, got,
             want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (centroid_q.size() == 0) begin
        report_mismatch("unexpected result, centroid_x", pop_data_o.centroid_x, '0);
      end else begin
        cloud_want = centroid_q.pop_front();
        if (pop_data_o.centroid_x !== cloud_want.centroid_x)
          report_mismatch("centroid_x", pop_data_o.centroid_x, cloud_want.centroid_x);
        if (pop_data_o.centroid_y !== cloud_want.centroid_y)
          report_mismatch("centroid_y", pop_data_o.centroid_y, cloud_want.centroid_y);
        if (pop_data_o.centroid_z !== cloud_want.centroid_z)
          report_mismatch("centroid_z", pop_data_o.centroid_z, cloud_want.centroid_z);
        if (pop_data_o.point_count !== cloud_want.point_count)
          report_mismatch("point_count", pop_data_o.point_count, cloud_want.point_count);
        if (pop_data_o.empty_cloud !== cloud_want.empty_cloud)
          report_mismatch("empty_cloud", pop_data_o.empty_cloud, cloud_want.empty_cloud);
        if (pop_data_o.count_overflow !== cloud_want.count_overflow)
          report_mismatch("count_overflow", pop_data_o.count_overflow,
                          cloud_want.count_overflow);
      end
    end
  end

  function automatic logic [CoordBits-1:0] mean_of(input longint sum, input int unsigned n);
    longint q;
    q = sum / longint'(n);
    if (q > longint'(32'sh7fff_ffff)) q = longint'(32'sh7fff_ffff);
    if (q < -longint'(64'h8000_0000)) q = -longint'(64'h8000_0000);
    return q[CoordBits-1:0];
  endfunction

  function automatic void accumulate_point(input igc_req_t p);
    igc_res_t res;
    if (p.intensity > low_bound && p.intensity < high_bound) begin
      if (point_total < MaxPoints) begin
        sum_x += longint'($signed(p.point_x));
        sum_y += longint'($signed(p.point_y));
        sum_z += longint'($signed(p.point_z));
        point_total++;
      end else begin
        overflow_seen = 1'b1;
      end
    end
    if (p.last_point) begin
      res = '0;
      if (point_total == 0) begin
        res.empty_cloud = 1'b1;
      end else begin
        res.centroid_x = mean_of(sum_x, point_total);
        res.centroid_y = mean_of(sum_y, point_total);
        res.centroid_z = mean_of(sum_z, point_total);
      end
      res.point_count = point_total[CntW-1:0];
      res.count_overflow = overflow_seen;
      centroid_q.push_back(res);
      sum_x = 0;
      sum_y = 0;
      sum_z = 0;
      point_total = 0;
      overflow_seen = 1'b0;
    end
  endfunction

  task automatic send_point(input igc_req_t p);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    push_data_i <= p;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    accumulate_point(p);
  endtask

  function automatic igc_req_t make_point(input logic [CoordBits-1:0] x,
                                          input logic [CoordBits-1:0] y,
                                          input logic [CoordBits-1:0] z,
                                          input int inten, input bit last);
    igc_req_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    p.intensity = IntenBits'(inten);
    p.last_point = last;
    return p;
  endfunction

  function automatic logic [CoordBits-1:0] rand_coord();
    case ($urandom_range(19))
      0: return CoordMin;
      1: return CoordMax;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic igc_req_t rand_point(input bit last);
    int lo;
    int hi;
    int pick;
    int inten;
    lo = low_bound;
    hi = high_bound;
    pick = $urandom_range(99);
    if (pick < 55 && hi > lo + 1) begin
      inten = $urandom_range(hi - 1, lo + 1);
    end else if (pick < 75) begin
      case ($urandom_range(3))
        0: inten = lo;
        1: inten = hi;
        2: inten = lo + 1;
        default: inten = hi - 1;
      endcase
    end else begin
      inten = $urandom_range(65535);
    end
    return make_point(rand_coord(), rand_coord(), rand_coord(), inten, last);
  endfunction

  task automatic send_cloud(input int n);
    for (int i = 0; i < n; i++) send_point(rand_point(i == n - 1));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (centroid_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [IntenBits-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == RegIntenLow) begin
      low_bound = val;
    end else if (idx == RegIntenHigh) begin
      high_bound = val;
    end
  endtask

  task automatic set_bounds(input int lo, input int hi);
    wait_drained();
    write_reg(RegIntenLow, IntenBits'(lo));
    write_reg(RegIntenHigh, IntenBits'(hi));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_bound_edges();
    idle_pct = 0;
    stall_pct = 0;
    // Reset bounds are 1100 and 2000: both ends are excluded.
    send_point(make_point(CoordMin, CoordMax, '0, 1101, 1'b0));
    send_point(make_point(CoordMax, CoordMin, '1, 1999, 1'b0));
    send_point(make_point(32'd5, 32'd5, 32'd5, 1100, 1'b0));
    send_point(make_point(32'd7, 32'd7, 32'd7, 2000, 1'b1));
    send_point(make_point(CoordMax, CoordMax, CoordMax, 0, 1'b1));
    // The mean truncates toward zero for both signs.
    send_point(make_point(-32'sd3, 32'd3, 32'd1, 1500, 1'b0));
    send_point(make_point('0, '0, '0, 1500, 1'b1));
    set_bounds(0, 65535);
    send_point(make_point(32'd11, 32'd11, 32'd11, 0, 1'b0));
    send_point(make_point(32'd13, 32'd13, 32'd13, 65535, 1'b0));
    send_point(make_point(CoordMin, CoordMin, CoordMin, 1, 1'b0));
    send_point(make_point(CoordMin, CoordMin, 32'hffff_fffe, 65534, 1'b1));
  endtask

  task automatic test_closed_window();
    set_bounds(65535, 0);
    send_point(make_point(32'd1, 32'd2, 32'd3, 1000, 1'b0));
    send_point(make_point(32'd1, 32'd2, 32'd3, 65535, 1'b1));
    set_bounds(5, 6);
    send_point(make_point(32'd1, 32'd2, 32'd3, 5, 1'b0));
    send_point(make_point(32'd1, 32'd2, 32'd3, 6, 1'b1));
  endtask

  task automatic test_spare_index();
    set_bounds(100, 200);
    write_reg(RegSpareA, '1);
    write_reg(RegSpareB, '0);
    cfg_valid_i <= 1'b0;
    send_point(make_point(32'd1000, -32'sd1000, 32'd77, 150, 1'b0));
    send_point(make_point(32'd1, 32'd1, 32'd1, 250, 1'b1));
  endtask

  task automatic test_long_hold();
    set_bounds(1100, 2000);
    idle_pct = 0;
    stall_pct = 0;
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    for (int c = 0; c < 30; c++) send_cloud($urandom_range(1, 3));
  endtask

  task automatic test_random_clouds();
    int idle_set[4];
    int stall_set[4];
    int sent;
    int n;
    idle_set = '{0, 80, 0, 24};
    stall_set = '{0, 0, 80, 24};
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_bounds(1100, 2000);
        1: begin
          n = $urandom_range(0, 60000);
          set_bounds(n, n + $urandom_range(2, 5000));
        end
        2: set_bounds(1, 3);
        default: set_bounds(0, 65535);
      endcase
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      sent = 0;
      while (sent < PhaseItems) begin
        n = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        send_cloud(n);
        sent += n;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bound_edges();
    test_closed_window();
    test_spare_index();
    test_long_hold();
    test_random_clouds();
    wait_drained();
    if (centroid_q.size() != 0) report_mismatch("results missing", centroid_q.size(), 0);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- intensity_gated_centroid.f -----
src/igc_pkg.sv
src/igc_front.sv
src/igc_jobq.sv
src/igc_back.sv
src/intensity_gated_centroid.sv
src/igc_checker.sv
tb/tb.sv
